// File: src/ipc_pkg.sv
package ipc_pkg;

  localparam int CFG_W = 14;

  localparam logic [1:0] REG_PACKET_WORDS      = 2'd0;
  localparam logic [1:0] REG_PACKETS_PER_GROUP = 2'd1;
  localparam logic [1:0] REG_HEADER_SIGNATURE  = 2'd2;

  localparam logic [13:0] PACKET_WORDS_RESET      = 14'd1024;
  localparam logic [7:0]  PACKETS_PER_GROUP_RESET = 8'd17;
  localparam logic [23:0] HEADER_SIGNATURE_RESET  = 24'd14613675;

  localparam logic [7:0] COUNT_RESET = 8'd17;
  localparam logic [7:0] COUNT_MAX   = 8'd255;

  typedef struct packed {
    logic [13:0] packet_words;
    logic [7:0]  packets_per_group;
    logic [23:0] header_signature;
  } cfg_t;

  typedef struct packed {
    logic [31:0] data_word;
    logic        stream_end;
  } in_item_t;

  typedef struct packed {
    logic        packet_is_header;
    logic [23:0] group_index;
    logic [23:0] group_id;
    logic        closed_valid;
    logic [23:0] closed_index;
    logic [7:0]  closed_count;
    logic        closed_bad;
    logic        partial_packet;
    logic        is_stream_end;
  } out_item_t;

  // One classified event: a finished packet, the stream end, or both.
  typedef struct packed {
    logic        complete;
    logic        stream_end;
    logic        is_header;
    logic [23:0] id;
  } pkt_ev_t;

  typedef struct packed {
    logic    valid;
    pkt_ev_t ev;
  } ev_req_t;

endpackage

// File: src/ipc_stream_if.sv
interface ipc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: src/ipc_front.sv
module ipc_front import ipc_pkg::*; #(
  parameter int MAX_PACKET_WORDS = 8192
) (
  input  logic         clk,
  input  logic         rst_n,
  input  cfg_t         cfg,
  ipc_stream_if.sink   in_chan,
  input  logic         ev_ready,
  output ev_req_t      ev_req
);

  localparam int LEN_W = $clog2(MAX_PACKET_WORDS + 1);
  localparam int POS_W = $clog2(MAX_PACKET_WORDS);
  localparam int CW    = ((LEN_W > CFG_W) ? LEN_W : CFG_W) + 1;
  localparam logic [CW-1:0] LEN_MIN = CW'(4);
  localparam logic [CW-1:0] LEN_MAX = CW'(MAX_PACKET_WORDS);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [23:0] first_r, first_nxt;
  logic [23:0] second_r, second_nxt;
  logic [23:0] id_r, id_nxt;
  logic [23:0] cur_tail_r, cur_tail_nxt;
  logic [23:0] prior_tail_r, prior_tail_nxt;

  logic [CW-1:0] pw_ext, eff, pos_ext;
  logic [31:0]   w;
  logic          accept, complete, is_header;

  assign in_chan.ready = ev_ready;
  assign accept = in_chan.valid && ev_ready;
  assign w      = in_chan.payload.data_word;

  always_comb begin
    pw_ext = CW'(cfg.packet_words);
    if (pw_ext < LEN_MIN) begin
      eff = LEN_MIN;
    end else if (pw_ext > LEN_MAX) begin
      eff = LEN_MAX;
    end else begin
      eff = pw_ext;
    end
    pos_ext = CW'(pos_r);

    first_nxt    = first_r;
    second_nxt   = second_r;
    id_nxt       = id_r;
    cur_tail_nxt = cur_tail_r;
    if (pos_ext == CW'(0)) begin
      first_nxt = w[31:8];
      id_nxt    = {w[7:0], 16'd0};
    end else if (pos_ext == CW'(1)) begin
      id_nxt = {id_r[23:16], w[31:16]};
    end else if (pos_ext == CW'(2)) begin
      second_nxt = w[31:8];
    end
    if (pos_ext == eff - CW'(2)) begin
      cur_tail_nxt = w[31:8];
    end

    complete  = (pos_ext + CW'(1)) >= eff;
    is_header = (first_nxt == cfg.header_signature) &&
                (second_nxt == cfg.header_signature) &&
                (prior_tail_r != cfg.header_signature);

    pos_nxt        = complete ? '0 : POS_W'(pos_ext + CW'(1));
    prior_tail_nxt = complete ? cur_tail_nxt : prior_tail_r;
  end

  assign ev_req.valid         = accept && (complete || in_chan.payload.stream_end);
  assign ev_req.ev.complete   = complete;
  assign ev_req.ev.stream_end = in_chan.payload.stream_end;
  assign ev_req.ev.is_header  = complete && is_header;
  assign ev_req.ev.id         = id_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      first_r      <= '0;
      second_r     <= '0;
      id_r         <= '0;
      cur_tail_r   <= '0;
      prior_tail_r <= '0;
    end else if (accept) begin
      if (in_chan.payload.stream_end) begin
        // stream over: start afresh
        pos_r        <= '0;
        first_r      <= '0;
        second_r     <= '0;
        id_r         <= '0;
        cur_tail_r   <= '0;
        prior_tail_r <= '0;
      end else begin
        pos_r        <= pos_nxt;
        first_r      <= first_nxt;
        second_r     <= second_nxt;
        id_r         <= id_nxt;
        cur_tail_r   <= cur_tail_nxt;
        prior_tail_r <= prior_tail_nxt;
      end
    end
  end

endmodule

// File: src/ipc_fifo.sv
module ipc_fifo import ipc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  ev_req_t push_req,
  output logic    push_ready,
  input  logic    pop,
  output ev_req_t head
);

  localparam int DEPTH = 2;

  pkt_ev_t     ent_r [DEPTH];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  count_r;
  logic        do_push, do_pop;

  assign push_ready = (count_r != 2'(DEPTH));
  assign do_push    = push_req.valid && push_ready;
  assign do_pop     = pop && (count_r != 2'd0);
  assign head.valid = (count_r != 2'd0);
  assign head.ev    = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_req.ev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + 2'(do_push) - 2'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'(DEPTH))
    else $error("queue count beyond depth");

endmodule

// File: src/ipc_back.sv
module ipc_back import ipc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  cfg_t         cfg,
  input  ev_req_t      head,
  output logic         pop,
  ipc_stream_if.source out_chan
);

  logic [7:0]  count_r, count_nxt;
  logic [23:0] group_r, group_nxt;
  logic        started_r, started_nxt;
  logic [23:0] ident_r, ident_nxt;
  logic        out_valid_r;
  out_item_t   out_data_r, res;
  pkt_ev_t     ev;

  assign ev  = head.ev;
  assign pop = head.valid && (!out_valid_r || out_chan.ready);

  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_data_r;

  always_comb begin
    count_nxt   = count_r;
    group_nxt   = group_r;
    started_nxt = started_r;
    ident_nxt   = ident_r;
    res         = '0;

    if (ev.complete) begin
      if (ev.is_header) begin
        if (started_r) begin
          res.closed_valid = 1'b1;
          res.closed_index = group_r;
          res.closed_count = count_r;
          res.closed_bad   = (count_r != cfg.packets_per_group);
          group_nxt        = group_r + 24'd1;
        end else begin
          started_nxt = 1'b1;
          group_nxt   = '0;
        end
        ident_nxt = ev.id;
        count_nxt = 8'd1;
      end else if (count_r < COUNT_MAX) begin
        count_nxt = count_r + 8'd1;
      end
      res.packet_is_header = ev.is_header;
    end

    if (ev.stream_end) begin
      res.partial_packet = !ev.complete;
      res.is_stream_end  = 1'b1;
      res.closed_valid   = started_nxt;
      res.closed_index   = started_nxt ? group_nxt : '0;
      res.closed_count   = started_nxt ? count_nxt : '0;
      res.closed_bad     = started_nxt && (count_nxt != cfg.packets_per_group);
    end

    res.group_index = started_nxt ? group_nxt : '0;
    res.group_id    = started_nxt ? ident_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= COUNT_RESET;
      group_r     <= '0;
      started_r   <= 1'b0;
      ident_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (pop) begin
        if (ev.stream_end) begin
          count_r   <= COUNT_RESET;
          group_r   <= '0;
          started_r <= 1'b0;
          ident_r   <= '0;
        end else begin
          count_r   <= count_nxt;
          group_r   <= group_nxt;
          started_r <= started_nxt;
          ident_r   <= ident_nxt;
        end
      end
    end
  end

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready |=> out_valid_r && $stable(out_data_r))
    else $error("pending result changed under stall");

  a_bad_needs_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.closed_bad |-> out_data_r.closed_valid)
    else $error("bad flag without closed integration");

  a_partial_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.partial_packet |-> out_data_r.is_stream_end)
    else $error("partial packet flagged away from stream end");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    pop && ev.stream_end |=> !started_r && count_r == COUNT_RESET)
    else $error("integration state not cleared after stream end");

endmodule

// File: src/integration_packet_checker.sv
// channel   dir  handshake      payload
// in_chan   in   valid/ready    data_word[31:0], stream_end
// out_chan  out  valid/ready    packet_is_header .. is_stream_end (one per packet or end)
// cfg_*     in   write enable   cfg_index[1:0], cfg_data[23:0]
//
// One word per cycle sustained while the event queue has room; a packet's result goes through
// the queue entry register, then the output register, before out_chan offers it.
// Two-entry event queue between classifier and counter keeps both sides moving.
// A stalled output fills the queue, after which in_chan.ready drops.
// Synchronous active-low reset; all state is ready on the cycle after reset.
module integration_packet_checker import ipc_pkg::*; #(
  parameter int MAX_PACKET_WORDS = 8192
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [23:0]  cfg_data,
  ipc_stream_if.sink   in_chan,
  ipc_stream_if.source out_chan
);

  cfg_t    cfg_r;
  ev_req_t ev_req, head;
  logic    ev_ready, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.packet_words      <= PACKET_WORDS_RESET;
      cfg_r.packets_per_group <= PACKETS_PER_GROUP_RESET;
      cfg_r.header_signature  <= HEADER_SIGNATURE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PACKET_WORDS:      cfg_r.packet_words      <= cfg_data[13:0];
        REG_PACKETS_PER_GROUP: cfg_r.packets_per_group <= cfg_data[7:0];
        REG_HEADER_SIGNATURE:  cfg_r.header_signature  <= cfg_data;
        default: ;
      endcase
    end
  end

  ipc_front #(.MAX_PACKET_WORDS(MAX_PACKET_WORDS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_chan  (in_chan),
    .ev_ready (ev_ready),
    .ev_req   (ev_req)
  );

  ipc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_req   (ev_req),
    .push_ready (ev_ready),
    .pop        (pop),
    .head       (head)
  );

  ipc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .head     (head),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule
